>>> sv/drrg_pkg.sv
// ----------------------------------------------------------------------------
// drrg_pkg
// Shared types, constants and tables for the dead reckoning return guidance
// block: datapath commands, controller status and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package drrg_pkg;

	// CORDIC working width and iteration count.
	localparam int CW          = 52;
	localparam int ZW          = 18;
	localparam int CORDIC_N    = 16;
	localparam int SQRT_N      = 32;

	// Start value of x for rotation, the inverse CORDIC gain in Q30.
	localparam logic signed [CW-1:0] CORDIC_GAIN = 52'sd652032874;

	// Navigation mode codes.
	localparam logic [1:0] NAV_IDLE      = 2'd0;
	localparam logic [1:0] NAV_RETURNING = 2'd1;
	localparam logic [1:0] NAV_DONE      = 2'd2;

	// Reach class codes.
	localparam logic [1:0] REACH_HERE = 2'd0;
	localparam logic [1:0] REACH_NEAR = 2'd1;
	localparam logic [1:0] REACH_FAR  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_METERS_PER_COUNT = 2'd0;
	localparam logic [1:0] REG_ARRIVE_DISTANCE  = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [23:0] MPC_RESET    = 24'd1678;
	localparam logic [20:0] ARRIVE_RESET = 21'd3277;

	// Operations the controller asks of the datapath.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_LOAD,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_DS_FIX,
		OP_ROT_INIT_REL,
		OP_ROT_INIT_ERR,
		OP_CORDIC_ITER,
		OP_SC_FIN,
		OP_HC_FIN,
		OP_PMUL_X,
		OP_PADD_X,
		OP_PMUL_Y,
		OP_PADD_Y,
		OP_SQ_X,
		OP_SQ_Y,
		OP_SQ_SUM,
		OP_SQRT_ITER,
		OP_CHECK,
		OP_BR_INIT,
		OP_BR_FIN,
		OP_OUT
	} dp_op_t;

	// Command word from the controller.
	typedef struct packed {
		dp_op_t     op;
		logic [3:0] iter;
		logic       rot;
	} dp_cmd_t;

	// Status word back to the controller.
	typedef struct packed {
		logic enc;
		logic returning;
		logic near;
	} dp_status_t;

	// Arctangent of 2^-i as a binary angle.
	function automatic logic [13:0] atan_step(input logic [3:0] i);
		logic [13:0] v;
		begin
			unique case (i)
				4'd0:  v = 14'd8192;
				4'd1:  v = 14'd4836;
				4'd2:  v = 14'd2555;
				4'd3:  v = 14'd1297;
				4'd4:  v = 14'd651;
				4'd5:  v = 14'd326;
				4'd6:  v = 14'd163;
				4'd7:  v = 14'd81;
				4'd8:  v = 14'd41;
				4'd9:  v = 14'd20;
				4'd10: v = 14'd10;
				4'd11: v = 14'd5;
				4'd12: v = 14'd3;
				4'd13: v = 14'd1;
				4'd14: v = 14'd1;
				default: v = 14'd0;
			endcase
			return v;
		end
	endfunction

endpackage

`default_nettype wire

>>> sv/drrg_ctrl.sv
// ----------------------------------------------------------------------------
// drrg_ctrl
// Sequencer for one tick: update, odometry step, distance root, bearing and
// gain. Drives the input and output handshakes and the datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module drrg_ctrl
	import drrg_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	typedef enum logic [23:0] {
		ST_IDLE    = 24'h000001,
		ST_LOAD    = 24'h000002,
		ST_MUL_LO  = 24'h000004,
		ST_MUL_HI  = 24'h000008,
		ST_DS_FIX  = 24'h000010,
		ST_SC_INIT = 24'h000020,
		ST_SC_ITER = 24'h000040,
		ST_SC_FIN  = 24'h000080,
		ST_PMUL_X  = 24'h000100,
		ST_PADD_X  = 24'h000200,
		ST_PMUL_Y  = 24'h000400,
		ST_PADD_Y  = 24'h000800,
		ST_SQ_X    = 24'h001000,
		ST_SQ_Y    = 24'h002000,
		ST_SQ_SUM  = 24'h004000,
		ST_SQRT    = 24'h008000,
		ST_CHECK   = 24'h010000,
		ST_BR_INIT = 24'h020000,
		ST_BR_ITER = 24'h040000,
		ST_BR_FIN  = 24'h080000,
		ST_HC_INIT = 24'h100000,
		ST_HC_ITER = 24'h200000,
		ST_HC_FIN  = 24'h400000,
		ST_OUT     = 24'h800000
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       out_valid_q;
	logic       out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// Next state, iteration count and datapath command.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd.op   = OP_NONE;
		cmd.iter = cnt_q[3:0];
		cmd.rot  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.op  = OP_LOAD;
				state_d = status.enc ? ST_MUL_LO : ST_SQ_X;
			end
			ST_MUL_LO: begin
				cmd.op  = OP_MUL_LO;
				state_d = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.op  = OP_MUL_HI;
				state_d = ST_DS_FIX;
			end
			ST_DS_FIX: begin
				cmd.op  = OP_DS_FIX;
				state_d = ST_SC_INIT;
			end
			ST_SC_INIT: begin
				cmd.op  = OP_ROT_INIT_REL;
				cnt_d   = '0;
				state_d = ST_SC_ITER;
			end
			ST_SC_ITER: begin
				cmd.op = OP_CORDIC_ITER;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == 5'(CORDIC_N - 1)) begin
					state_d = ST_SC_FIN;
				end
			end
			ST_SC_FIN: begin
				cmd.op  = OP_SC_FIN;
				state_d = ST_PMUL_X;
			end
			ST_PMUL_X: begin
				cmd.op  = OP_PMUL_X;
				state_d = ST_PADD_X;
			end
			ST_PADD_X: begin
				cmd.op  = OP_PADD_X;
				state_d = ST_PMUL_Y;
			end
			ST_PMUL_Y: begin
				cmd.op  = OP_PMUL_Y;
				state_d = ST_PADD_Y;
			end
			ST_PADD_Y: begin
				cmd.op  = OP_PADD_Y;
				state_d = ST_SQ_X;
			end
			ST_SQ_X: begin
				cmd.op  = OP_SQ_X;
				state_d = ST_SQ_Y;
			end
			ST_SQ_Y: begin
				cmd.op  = OP_SQ_Y;
				state_d = ST_SQ_SUM;
			end
			ST_SQ_SUM: begin
				cmd.op  = OP_SQ_SUM;
				cnt_d   = '0;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op = OP_SQRT_ITER;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == 5'(SQRT_N - 1)) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.op  = OP_CHECK;
				state_d = (status.returning && !status.near) ? ST_BR_INIT : ST_OUT;
			end
			ST_BR_INIT: begin
				cmd.op  = OP_BR_INIT;
				cnt_d   = '0;
				state_d = ST_BR_ITER;
			end
			ST_BR_ITER: begin
				cmd.op  = OP_CORDIC_ITER;
				cmd.rot = 1'b0;
				cnt_d   = cnt_q + 5'd1;
				if (cnt_q == 5'(CORDIC_N - 1)) begin
					state_d = ST_BR_FIN;
				end
			end
			ST_BR_FIN: begin
				cmd.op  = OP_BR_FIN;
				state_d = ST_HC_INIT;
			end
			ST_HC_INIT: begin
				cmd.op  = OP_ROT_INIT_ERR;
				cnt_d   = '0;
				state_d = ST_HC_ITER;
			end
			ST_HC_ITER: begin
				cmd.op = OP_CORDIC_ITER;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == 5'(CORDIC_N - 1)) begin
					state_d = ST_HC_FIN;
				end
			end
			ST_HC_FIN: begin
				cmd.op  = OP_HC_FIN;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, counter and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/drrg_datapath.sv
// ----------------------------------------------------------------------------
// drrg_datapath
// Odometry state, configuration registers, shared CORDIC unit, bit-serial
// square root and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module drrg_datapath
	import drrg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	output dp_status_t              status,
	input  wire logic               cfg_write,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [23:0]        cfg_data,
	input  wire logic               imu_valid,
	input  wire logic signed [15:0] yaw_angle,
	input  wire logic               enc_valid,
	input  wire logic signed [31:0] left_count,
	input  wire logic signed [31:0] right_count,
	input  wire logic               start_return,
	input  wire logic               reset_origin,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic [1:0]              nav_state,
	output logic                    drive_active,
	output logic [32:0]             distance_home,
	output logic signed [15:0]      heading_error,
	output logic [16:0]             speed_gain,
	output logic [1:0]              reach_class
);

	// Captured input word.
	logic        imu_q, enc_q, sr_q, ro_q;
	logic [15:0] yaw_q;
	logic [31:0] lt_q, rt_q;

	// Configuration.
	logic [23:0] mpc_q;
	logic [20:0] arr_q;

	// Architectural state.
	logic signed [31:0] px_q, py_q;
	logic [15:0]        hnow_q, horg_q;
	logic [31:0]        lref_q, rref_q;
	logic [1:0]         mode_q;

	// Working registers.
	logic [15:0]        rel_q, herr_q;
	logic signed [32:0] sum_q;
	logic [39:0]        plo_q;
	logic signed [41:0] phi_q;
	logic signed [34:0] ds_q;
	logic signed [17:0] c_q, s_q;
	logic signed [52:0] prod_q;
	logic [63:0]        sqx_q, sqy_q, n_q, r_q, b_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic               flip_q, zero_q, base_q;
	logic [16:0]        gain_q;
	logic               drive_q;

	// Load-step update, applied in tick order.
	logic [1:0]         mode_a;
	logic [15:0]        horg_a, hnow_b, horg_b;
	logic               pos_clr;
	logic [31:0]        lref_a, rref_a, dl, dr;
	logic signed [32:0] sum_d;

	always_comb begin
		mode_a  = sr_q ? NAV_RETURNING : mode_q;
		horg_a  = horg_q;
		pos_clr = ro_q;
		lref_a  = lref_q;
		rref_a  = rref_q;
		if (ro_q) begin
			horg_a = hnow_q;
			lref_a = '0;
			rref_a = '0;
			mode_a = NAV_IDLE;
		end
		hnow_b = imu_q ? yaw_q : hnow_q;
		horg_b = horg_a;
		if (imu_q && horg_a == 16'd0 && (pos_clr || (px_q == 32'sd0 && py_q == 32'sd0))) begin
			horg_b = yaw_q;
		end
		dl    = lt_q - lref_a;
		dr    = rt_q - rref_a;
		sum_d = 33'($signed(dl)) + 33'($signed(dr));
	end

	// Step length: round, shift to Q16.16 and clip.
	logic signed [57:0] ds_full, ds_shift;
	logic signed [34:0] ds_d;
	localparam logic signed [57:0] DS_LIM = 58'sd8589934592;

	always_comb begin
		ds_full  = $signed({phi_q, 16'h0000}) + $signed({18'b0, plo_q});
		ds_shift = (ds_full + 58'sd256) >>> 9;
		if (ds_shift > DS_LIM) begin
			ds_d = 35'(DS_LIM);
		end else if (ds_shift < -DS_LIM) begin
			ds_d = 35'(-DS_LIM);
		end else begin
			ds_d = ds_shift[34:0];
		end
	end

	// Position increment with rounding and saturation.
	logic signed [52:0] inc_full;
	logic signed [37:0] pos_sum;
	logic signed [31:0] pos_new;
	logic signed [31:0] pos_cur;

	always_comb begin
		pos_cur  = (cmd.op == OP_PADD_Y) ? py_q : px_q;
		inc_full = (prod_q + 53'sd32768) >>> 16;
		pos_sum  = 38'(pos_cur) + inc_full[37:0];
		if (pos_sum > 38'sd2147483647) begin
			pos_new = 32'sh7FFFFFFF;
		end else if (pos_sum < -38'sd2147483648) begin
			pos_new = 32'sh80000000;
		end else begin
			pos_new = pos_sum[31:0];
		end
	end

	// One CORDIC micro-rotation.
	logic signed [CW-1:0] xs, ys;
	logic                 ccw;
	logic signed [ZW-1:0] zstep;

	always_comb begin
		xs    = cx_q >>> cmd.iter;
		ys    = cy_q >>> cmd.iter;
		zstep = $signed({4'b0, atan_step(cmd.iter)});
		if (cmd.rot) begin
			ccw = !cz_q[ZW-1];
		end else begin
			ccw = cy_q[CW-1] || (cy_q == '0);
		end
	end

	// CORDIC result scaling to Q1.16, clipped and unfolded.
	logic signed [CW-1:0] cr_x, cr_y;
	logic signed [17:0]   cos_d, sin_d;

	always_comb begin
		cr_x = (cx_q + 52'sd8192) >>> 14;
		cr_y = (cy_q + 52'sd8192) >>> 14;
		if (cr_x > 52'sd65536) begin
			cos_d = 18'sd65536;
		end else if (cr_x < -52'sd65536) begin
			cos_d = -18'sd65536;
		end else begin
			cos_d = cr_x[17:0];
		end
		if (cr_y > 52'sd65536) begin
			sin_d = 18'sd65536;
		end else if (cr_y < -52'sd65536) begin
			sin_d = -18'sd65536;
		end else begin
			sin_d = cr_y[17:0];
		end
		if (flip_q) begin
			cos_d = -cos_d;
			sin_d = -sin_d;
		end
	end

	// Rotation start angle folded into the right half plane.
	logic [15:0]  rot_ang, rot_fold;
	logic         rot_flip;

	always_comb begin
		rot_ang  = (cmd.op == OP_ROT_INIT_ERR) ? herr_q : rel_q;
		rot_flip = ($signed(rot_ang) > 16'sd16384) || ($signed(rot_ang) < -16'sd16384);
		rot_fold = rot_flip ? (rot_ang ^ 16'h8000) : rot_ang;
	end

	// Square root step and magnitudes.
	logic [63:0] rb;
	logic [31:0] abs_x, abs_y;
	logic [32:0] home_dist;
	logic        near;
	logic [23:0] six_arr;
	logic [15:0] brg;

	always_comb begin
		rb        = r_q + b_q;
		abs_x     = px_q[31] ? 32'(-px_q) : px_q;
		abs_y     = py_q[31] ? 32'(-py_q) : py_q;
		home_dist = r_q[32:0];
		near      = home_dist < 33'(arr_q);
		six_arr   = (24'(arr_q) << 2) + (24'(arr_q) << 1);
		brg       = zero_q ? 16'hC000 : ((base_q ? 16'h8000 : 16'h0000) + cz_q[15:0]);
	end

	assign status.enc       = enc_q;
	assign status.returning = (mode_q == NAV_RETURNING);
	assign status.near      = near;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpc_q <= MPC_RESET;
			arr_q <= ARRIVE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_METERS_PER_COUNT: mpc_q <= cfg_data;
				REG_ARRIVE_DISTANCE:  arr_q <= cfg_data[20:0];
				default: ;
			endcase
		end
	end

	// Odometry state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q   <= '0;
			py_q   <= '0;
			hnow_q <= '0;
			horg_q <= '0;
			lref_q <= '0;
			rref_q <= '0;
			mode_q <= NAV_IDLE;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					mode_q <= mode_a;
					hnow_q <= hnow_b;
					horg_q <= horg_b;
					if (pos_clr) begin
						px_q <= '0;
						py_q <= '0;
					end
					lref_q <= enc_q ? lt_q : lref_a;
					rref_q <= enc_q ? rt_q : rref_a;
				end
				OP_PADD_X: px_q <= pos_new;
				OP_PADD_Y: py_q <= pos_new;
				OP_CHECK: begin
					if (mode_q == NAV_RETURNING && near) begin
						mode_q <= NAV_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of one tick.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				imu_q <= imu_valid;
				yaw_q <= yaw_angle;
				enc_q <= enc_valid;
				lt_q  <= left_count;
				rt_q  <= right_count;
				sr_q  <= start_return;
				ro_q  <= reset_origin;
			end
			OP_LOAD: begin
				rel_q   <= hnow_b - horg_b;
				sum_q   <= sum_d;
				herr_q  <= '0;
				gain_q  <= '0;
				drive_q <= 1'b0;
			end
			OP_MUL_LO: plo_q <= 40'(sum_q[15:0]) * 40'(mpc_q);
			OP_MUL_HI: phi_q <= $signed(sum_q[32:16]) * $signed({1'b0, mpc_q});
			OP_DS_FIX: ds_q <= ds_d;
			OP_ROT_INIT_REL, OP_ROT_INIT_ERR: begin
				cx_q   <= CORDIC_GAIN;
				cy_q   <= '0;
				cz_q   <= ZW'($signed(rot_fold));
				flip_q <= rot_flip;
			end
			OP_CORDIC_ITER: begin
				// Rotation drives z toward zero; vectoring sums the angle turned.
				if (ccw) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - zstep;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + zstep;
				end
			end
			OP_SC_FIN: begin
				c_q <= cos_d;
				s_q <= sin_d;
			end
			OP_HC_FIN: gain_q <= cos_d[17] ? 17'd0 : cos_d[16:0];
			OP_PMUL_X: prod_q <= ds_q * c_q;
			OP_PMUL_Y: prod_q <= ds_q * s_q;
			OP_SQ_X: sqx_q <= 64'(abs_x) * 64'(abs_x);
			OP_SQ_Y: sqy_q <= 64'(abs_y) * 64'(abs_y);
			OP_SQ_SUM: begin
				n_q <= sqx_q + sqy_q;
				r_q <= '0;
				b_q <= 64'h4000_0000_0000_0000;
			end
			OP_SQRT_ITER: begin
				if (n_q >= rb) begin
					n_q <= n_q - rb;
					r_q <= (r_q >> 1) + b_q;
				end else begin
					r_q <= r_q >> 1;
				end
				b_q <= b_q >> 2;
			end
			OP_BR_INIT: begin
				// Bearing of the vector back to the origin; mirror into x >= 0.
				zero_q  <= (px_q == 32'sd0) && (py_q == 32'sd0);
				base_q  <= !px_q[31] && (px_q != 32'sd0);
				drive_q <= 1'b1;
				cz_q    <= '0;
				if (!px_q[31] && (px_q != 32'sd0)) begin
					cx_q <= CW'(px_q) <<< 16;
					cy_q <= CW'(py_q) <<< 16;
				end else begin
					cx_q <= -(CW'(px_q) <<< 16);
					cy_q <= -(CW'(py_q) <<< 16);
				end
			end
			OP_BR_FIN: herr_q <= brg - rel_q;
			default: ;
		endcase
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			pos_x         <= px_q;
			pos_y         <= py_q;
			nav_state     <= mode_q;
			drive_active  <= drive_q;
			distance_home <= home_dist;
			heading_error <= herr_q;
			speed_gain    <= gain_q;
			if (near) begin
				reach_class <= REACH_HERE;
			end else if (home_dist < 33'(six_arr)) begin
				reach_class <= REACH_NEAR;
			end else begin
				reach_class <= REACH_FAR;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/dead_reckoning_return_guidance_unit.sv
// ----------------------------------------------------------------------------
// dead_reckoning_return_guidance_unit
// Wheel and yaw dead reckoning with return-to-origin guidance.
// ----------------------------------------------------------------------------
// Usage:
// One input word per tick carries yaw and encoder totals with their valid
// flags plus the start-return and reset-origin flags; each word yields
// exactly one output word with position, mode, distance, heading error,
// speed gain and reach class. Both channels use valid/ready handshakes.
// Each word is worked through in steps: the bit-serial square root
// runs 32 iterations, each CORDIC pass (sine and cosine for the step,
// bearing to the origin, cosine of the heading error) costs 16
// iterations of the one shared CORDIC unit, and the rest are multiply
// and add steps. One word is worked on at a time.
// The next word is taken while the last result still waits in the output
// register; a stalled receiver holds the finished word and the block waits
// before writing the next one. The configuration channel is always ready.
// Reset clears position, headings, encoder references and mode, and loads
// the default register values.
// ----------------------------------------------------------------------------
`default_nettype none

module dead_reckoning_return_guidance_unit
	import drrg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               imu_valid,
	input  wire logic signed [15:0] yaw_angle,
	input  wire logic               enc_valid,
	input  wire logic signed [31:0] left_count,
	input  wire logic signed [31:0] right_count,
	input  wire logic               start_return,
	input  wire logic               reset_origin,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic [1:0]              nav_state,
	output logic                    drive_active,
	output logic [32:0]             distance_home,
	output logic signed [15:0]      heading_error,
	output logic [16:0]             speed_gain,
	output logic [1:0]              reach_class,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [23:0]        cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	// Tick sequencer.
	drrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic and state.
	drrg_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_write     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.imu_valid     (imu_valid),
		.yaw_angle     (yaw_angle),
		.enc_valid     (enc_valid),
		.left_count    (left_count),
		.right_count   (right_count),
		.start_return  (start_return),
		.reset_origin  (reset_origin),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.nav_state     (nav_state),
		.drive_active  (drive_active),
		.distance_home (distance_home),
		.heading_error (heading_error),
		.speed_gain    (speed_gain),
		.reach_class   (reach_class)
	);

endmodule

`default_nettype wire
